### src/trpu_pkg.sv
// shared types and constants for the training packet receive unit
package trpu_pkg;

    localparam int CFG_ADDR_W = 5;

    localparam logic [1:0] REQ_PACKET = 2'd0;
    localparam logic [1:0] REQ_DONE   = 2'd1;
    localparam logic [1:0] REQ_DEQ    = 2'd2;

    localparam logic [2:0] REG_PHASE_BIT_POS     = 3'd0;
    localparam logic [2:0] REG_STOP_KEY_MASK     = 3'd1;
    localparam logic [2:0] REG_STOP_KEY_MATCH    = 3'd2;
    localparam logic [2:0] REG_STOP_DECISION_POS = 3'd3;
    localparam logic [2:0] REG_INDEX_MASK        = 3'd4;
    localparam logic [2:0] REG_ARRIVAL_TARGET    = 3'd5;
    localparam logic [2:0] REG_COUNTER_MODE      = 3'd6;

    localparam logic [1:0] SYNC_PARTIES = 2'd2;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_STOP,
        CMD_FWD,
        CMD_BWD,
        CMD_DONE,
        CMD_DEQ
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] key;
        logic [31:0] payload;
    } req_item_t;

    typedef struct packed {
        logic        store_write;
        logic        store_buffer;
        logic [7:0]  store_index;
        logic [31:0] store_value;
        logic        advance_tick;
        logic        stop_flag;
        logic        start_delta_work;
        logic        queue_overflow;
        logic        deq_valid;
        logic [31:0] deq_key;
        logic [31:0] deq_payload;
    } rsp_item_t;

    typedef struct packed {
        logic [4:0]  phase_bit_pos;
        logic [31:0] stop_key_mask;
        logic [31:0] stop_key_match;
        logic [4:0]  stop_decision_pos;
        logic [7:0]  index_mask;
        logic [31:0] arrival_target;
        logic        counter_mode;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        stop_bit;
        logic [7:0]  index;
        logic [31:0] key;
        logic [31:0] payload;
    } cmd_t;

endpackage

### src/trpu_regs.sv
// configuration registers behind the apb port
module trpu_regs
    import trpu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_sel;
    logic       wr_en;

    assign reg_sel = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_PHASE_BIT_POS:     cfg_next.phase_bit_pos = pwdata[4:0];
                REG_STOP_KEY_MASK:     cfg_next.stop_key_mask = pwdata;
                REG_STOP_KEY_MATCH:    cfg_next.stop_key_match = pwdata;
                REG_STOP_DECISION_POS: cfg_next.stop_decision_pos = pwdata[4:0];
                REG_INDEX_MASK:        cfg_next.index_mask = pwdata[7:0];
                REG_ARRIVAL_TARGET:    cfg_next.arrival_target = pwdata;
                REG_COUNTER_MODE:      cfg_next.counter_mode = pwdata[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_PHASE_BIT_POS:     prdata = {27'd0, cfg_reg.phase_bit_pos};
            REG_STOP_KEY_MASK:     prdata = cfg_reg.stop_key_mask;
            REG_STOP_KEY_MATCH:    prdata = cfg_reg.stop_key_match;
            REG_STOP_DECISION_POS: prdata = {27'd0, cfg_reg.stop_decision_pos};
            REG_INDEX_MASK:        prdata = {24'd0, cfg_reg.index_mask};
            REG_ARRIVAL_TARGET:    prdata = cfg_reg.arrival_target;
            REG_COUNTER_MODE:      prdata = {31'd0, cfg_reg.counter_mode};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_bit_pos     <= 5'd0;
            cfg_reg.stop_key_mask     <= 32'd0;
            cfg_reg.stop_key_match    <= 32'd1;
            cfg_reg.stop_decision_pos <= 5'd0;
            cfg_reg.index_mask        <= 8'd31;
            cfg_reg.arrival_target    <= 32'd0;
            cfg_reg.counter_mode      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### src/trpu_front.sv
// request classifier: sorts each item into a back-end command
module trpu_front
    import trpu_pkg::*;
(
    input  req_item_t req,
    input  cfg_t      cfg,
    output cmd_t      cmd
);

    logic is_stop;
    logic phase;

    assign is_stop = (req.key & cfg.stop_key_mask) == cfg.stop_key_match;
    assign phase   = req.key[cfg.phase_bit_pos];

    always_comb
    begin
        cmd.stop_bit = req.key[cfg.stop_decision_pos];
        cmd.index    = req.key[7:0] & cfg.index_mask;
        cmd.key      = req.key;
        cmd.payload  = req.payload;
        case (req.req_type)
            REQ_PACKET:
            begin
                if (is_stop)
                    cmd.kind = CMD_STOP;
                else if (!phase)
                    cmd.kind = CMD_FWD;
                else
                    cmd.kind = CMD_BWD;
            end
            REQ_DONE: cmd.kind = CMD_DONE;
            REQ_DEQ:  cmd.kind = CMD_DEQ;
            default:  cmd.kind = CMD_NOP;
        endcase
    end

endmodule

### src/trpu_fifo.sv
// two-entry command queue between classifier and back end
module trpu_fifo
    import trpu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/trpu_back.sv
// back end: scoreboard, semaphore, stop latch and backprop ring queue
module trpu_back
    import trpu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    logic [63:0]   mem [QUEUE_DEPTH];
    logic [63:0]   rdata_reg;

    logic [31:0]   board_reg;
    logic [31:0]   board_next;
    logic          bufsel_reg;
    logic          bufsel_next;
    logic [1:0]    sync_reg;
    logic [1:0]    sync_next;
    logic          stop_reg;
    logic          stop_next;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] tail_next;
    logic          busy_reg;
    logic          busy_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    rsp_item_t     rsp_reg;
    rsp_item_t     rsp_next;

    logic [31:0]   board_upd;
    logic [AW-1:0] tail_inc;
    logic [AW-1:0] head_inc;
    logic          q_wr;
    logic          sem_adv;
    logic [1:0]    sem_cnt;

    assign cmd_pop   = cmd_valid && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign tail_inc  = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
    assign head_inc  = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    assign sem_adv   = sync_reg == 2'd0;
    assign sem_cnt   = sem_adv ? SYNC_PARTIES : sync_reg - 2'd1;

    always_comb
    begin
        if (cfg.counter_mode)
            board_upd = board_reg + 32'd1;
        else if (cmd.index[7:5] == 3'd0)
            board_upd = board_reg | (32'd1 << cmd.index[4:0]);
        else
            board_upd = board_reg;
    end

    always_comb
    begin
        board_next     = board_reg;
        bufsel_next    = bufsel_reg;
        sync_next      = sync_reg;
        stop_next      = stop_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        busy_next      = busy_reg;
        q_wr           = 1'b0;
        rsp_next       = '0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (cmd_pop)
        begin
            rsp_valid_next = 1'b1;
            case (cmd.kind)
                CMD_STOP:
                begin
                    stop_next             = cmd.stop_bit;
                    sync_next             = sem_cnt;
                    rsp_next.advance_tick = sem_adv;
                end
                CMD_FWD:
                begin
                    rsp_next.store_write  = 1'b1;
                    rsp_next.store_buffer = bufsel_reg;
                    rsp_next.store_index  = cmd.index;
                    rsp_next.store_value  = cmd.payload;
                    if (board_upd == cfg.arrival_target)
                    begin
                        board_next            = 32'd0;
                        bufsel_next           = ~bufsel_reg;
                        sync_next             = sem_cnt;
                        rsp_next.advance_tick = sem_adv;
                    end
                    else
                    begin
                        board_next = board_upd;
                    end
                end
                CMD_BWD:
                begin
                    if (tail_inc == head_reg)
                    begin
                        rsp_next.queue_overflow = 1'b1;
                    end
                    else
                    begin
                        q_wr      = 1'b1;
                        tail_next = tail_inc;
                        if (!busy_reg)
                        begin
                            busy_next                 = 1'b1;
                            rsp_next.start_delta_work = 1'b1;
                        end
                    end
                end
                CMD_DONE:
                begin
                    sync_next             = sem_cnt;
                    rsp_next.advance_tick = sem_adv;
                end
                CMD_DEQ:
                begin
                    if (head_reg != tail_reg)
                    begin
                        rsp_next.deq_valid   = 1'b1;
                        rsp_next.deq_key     = rdata_reg[63:32];
                        rsp_next.deq_payload = rdata_reg[31:0];
                        head_next            = head_inc;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    rsp_next = '0;
                end
            endcase
            rsp_next.stop_flag = stop_next;
        end
        else
        begin
            rsp_next = rsp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr)
            mem[tail_reg] <= {cmd.key, cmd.payload};
    end

    // prefetch the entry at the new head, forwarding a same-cycle write
    always_ff @(posedge clk)
    begin
        if (q_wr && (tail_reg == head_next))
            rdata_reg <= {cmd.key, cmd.payload};
        else
            rdata_reg <= mem[head_next];
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_reg     <= 32'd0;
            bufsel_reg    <= 1'b0;
            sync_reg      <= SYNC_PARTIES;
            stop_reg      <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            board_reg     <= board_next;
            bufsel_reg    <= bufsel_next;
            sync_reg      <= sync_next;
            stop_reg      <= stop_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_sync_range: assert property (@(posedge clk) disable iff (!rst_n)
        sync_reg != 2'd3)
        else $error("semaphore count out of range");

    a_adv_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && rsp_next.advance_tick) |=> (sync_reg == SYNC_PARTIES))
        else $error("tick advanced without rearming semaphore");

    a_ovf_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && rsp_next.queue_overflow) |=> $stable(tail_reg))
        else $error("dropped item moved the queue tail");

    a_deq_head: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && rsp_next.deq_valid) |=> (head_reg != $past(head_reg)))
        else $error("dequeue did not advance head");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && rsp_next.start_delta_work) |=> busy_reg)
        else $error("delta work started without busy set");

endmodule

### src/training_packet_receive_unit.sv
// top level of the training packet receive unit
// path: an accepted item goes through the command queue, then the result register
// throughput: one item per cycle; the back end retires one command per cycle unless rsp stalls
// the backprop queue read is prefetched from the head pointer so dequeues run back to back
// reset: asynchronous active low; clears control state, config to defaults, semaphore to two
// the backprop queue memory is not cleared; only entries between head and tail are read
module training_packet_receive_unit
    import trpu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_item_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_item_t             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t cfg;
    cmd_t front_cmd;
    cmd_t back_cmd;
    logic fifo_full;
    logic fifo_not_empty;
    logic back_pop;

    assign req_ready = !fifo_full;

    trpu_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    trpu_front u_front (
        .req (req),
        .cfg (cfg),
        .cmd (front_cmd)
    );

    trpu_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_valid && req_ready),
        .push_cmd  (front_cmd),
        .full      (fifo_full),
        .pop       (back_pop),
        .not_empty (fifo_not_empty),
        .pop_cmd   (back_cmd)
    );

    trpu_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (fifo_not_empty),
        .cmd       (back_cmd),
        .cmd_pop   (back_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

### test/training_packet_receive_unit_test.sv
// testbench for the training packet receive unit: queued stimulus, predicted results, compare
`timescale 1ns / 1ps

module training_packet_receive_unit_test;
    import trpu_pkg::*;

    localparam int FIFO_DEPTH = 256;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_item_t             req = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_item_t             rsp;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // predictor state
    cfg_t        cur_cfg;
    logic [31:0] board;
    logic        buf_sel;
    logic [1:0]  sync_cnt;
    logic        stop_latch;
    logic [63:0] delta_fifo [0:FIFO_DEPTH-1];
    int          dq_head;
    int          dq_tail;
    logic        delta_busy;

    req_item_t   pending_reqs[$];
    rsp_item_t   predicted_rsps[$];
    bit          req_taken = 1'b0;
    bit          rsp_hold = 1'b0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          err_count = 0;
    int          rsp_count = 0;
    event        hold_go;

    training_packet_receive_unit #(
        .QUEUE_DEPTH(FIFO_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic sem_tick();
        if (sync_cnt == 2'd0)
        begin
            sync_cnt = SYNC_PARTIES;
            return 1'b1;
        end
        sync_cnt = sync_cnt - 2'd1;
        return 1'b0;
    endfunction

    function automatic rsp_item_t next_rsp(req_item_t r);
        rsp_item_t  o;
        int         nt;
        logic [7:0] idx;
        o = '0;
        case (r.req_type)
            REQ_PACKET:
            begin
                if ((r.key & cur_cfg.stop_key_mask) == cur_cfg.stop_key_match)
                begin
                    stop_latch = r.key[cur_cfg.stop_decision_pos];
                    o.advance_tick = sem_tick();
                end
                else if (!r.key[cur_cfg.phase_bit_pos])
                begin
                    idx = r.key[7:0] & cur_cfg.index_mask;
                    o.store_write = 1'b1;
                    o.store_buffer = buf_sel;
                    o.store_index = idx;
                    o.store_value = r.payload;
                    if (cur_cfg.counter_mode)
                        board = board + 32'd1;
                    else if (idx < 8'd32)
                        board[idx[4:0]] = 1'b1;
                    if (board == cur_cfg.arrival_target)
                    begin
                        board = '0;
                        buf_sel = ~buf_sel;
                        o.advance_tick = sem_tick();
                    end
                end
                else
                begin
                    nt = (dq_tail + 1) % FIFO_DEPTH;
                    if (nt == dq_head)
                        o.queue_overflow = 1'b1;
                    else
                    begin
                        delta_fifo[dq_tail] = {r.key, r.payload};
                        dq_tail = nt;
                        if (!delta_busy)
                        begin
                            delta_busy = 1'b1;
                            o.start_delta_work = 1'b1;
                        end
                    end
                end
            end
            REQ_DONE:
                o.advance_tick = sem_tick();
            REQ_DEQ:
            begin
                if (dq_head != dq_tail)
                begin
                    {o.deq_key, o.deq_payload} = delta_fifo[dq_head];
                    o.deq_valid = 1'b1;
                    dq_head = (dq_head + 1) % FIFO_DEPTH;
                end
                else
                    delta_busy = 1'b0;
            end
            default:
            begin
            end
        endcase
        o.stop_flag = stop_latch;
        return o;
    endfunction

    function automatic string rsp_text(rsp_item_t r);
        return $sformatf("wr=%0d buf=%0d idx=%02h val=%08h adv=%0d stop=%0d start=%0d %s",
                         r.store_write, r.store_buffer, r.store_index, r.store_value,
                         r.advance_tick, r.stop_flag, r.start_delta_work,
                         $sformatf("ovf=%0d dv=%0d dkey=%08h dpay=%08h", r.queue_overflow,
                                   r.deq_valid, r.deq_key, r.deq_payload));
    endfunction

    // key with given phase bit, non-stop within 8 tries; forward indexes favor target bits
    function automatic logic [31:0] packet_key(logic phase);
        logic [31:0] k;
        int          p;
        for (int tries = 0; tries < 8; tries++)
        begin
            k = $urandom;
            if (!phase && !cur_cfg.counter_mode && cur_cfg.arrival_target != 0
                && $urandom_range(9) != 0)
            begin
                do
                    p = $urandom_range(31);
                while (!cur_cfg.arrival_target[p]);
                k[7:0] = 8'(p);
            end
            k[cur_cfg.phase_bit_pos] = phase;
            if ((k & cur_cfg.stop_key_mask) != cur_cfg.stop_key_match)
                break;
        end
        return k;
    endfunction

    function automatic logic [31:0] stop_key();
        return ($urandom & ~cur_cfg.stop_key_mask) | (cur_cfg.stop_key_match & cur_cfg.stop_key_mask);
    endfunction

    function automatic void queue_req(logic [1:0] t, logic [31:0] k, logic [31:0] p);
        req_item_t r;
        r.req_type = t;
        r.key = k;
        r.payload = p;
        pending_reqs.push_back(r);
    endfunction

    task automatic queue_random(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                queue_req(REQ_PACKET, packet_key(1'b0), $urandom);
            else if (pick < 55)
                queue_req(REQ_PACKET, stop_key(), $urandom);
            else if (pick < 72)
                queue_req(REQ_PACKET, packet_key(1'b1), $urandom);
            else if (pick < 84)
                queue_req(REQ_DEQ, $urandom, $urandom);
            else if (pick < 93)
                queue_req(REQ_DONE, $urandom, $urandom);
            else if (pick < 97)
                queue_req(REQ_UNUSED, $urandom, $urandom);
            else
                queue_req(REQ_PACKET, $urandom, $urandom);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_regs(input cfg_t c);
        write_reg(REG_PHASE_BIT_POS, 32'(c.phase_bit_pos));
        write_reg(REG_STOP_KEY_MASK, c.stop_key_mask);
        write_reg(REG_STOP_KEY_MATCH, c.stop_key_match);
        write_reg(REG_STOP_DECISION_POS, 32'(c.stop_decision_pos));
        write_reg(REG_INDEX_MASK, 32'(c.index_mask));
        write_reg(REG_ARRIVAL_TARGET, c.arrival_target);
        write_reg(REG_COUNTER_MODE, 32'(c.counter_mode));
        cur_cfg = c;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_valid || predicted_rsps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!req_valid || req_taken)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
        req_taken = 1'b0;
    end

    // receiver
    always @(negedge clk)
    begin
        rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin : monitor
        rsp_item_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_count++;
                if (predicted_rsps.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("result %0d unexpected: %s", rsp_count, rsp_text(rsp));
                end
                else
                begin
                    want = predicted_rsps.pop_front();
                    if (rsp.store_write !== want.store_write
                        || rsp.store_buffer !== want.store_buffer
                        || rsp.store_index !== want.store_index
                        || rsp.store_value !== want.store_value
                        || rsp.advance_tick !== want.advance_tick
                        || rsp.stop_flag !== want.stop_flag
                        || rsp.start_delta_work !== want.start_delta_work
                        || rsp.queue_overflow !== want.queue_overflow
                        || rsp.deq_valid !== want.deq_valid
                        || rsp.deq_key !== want.deq_key
                        || rsp.deq_payload !== want.deq_payload)
                    begin
                        err_count++;
                        if (err_count <= 10)
                        begin
                            $display("result %0d mismatch", rsp_count);
                            $display("  expected %s", rsp_text(want));
                            $display("  actual   %s", rsp_text(rsp));
                        end
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                predicted_rsps.push_back(next_rsp(req));
                req_taken = 1'b1;
            end
        end
    end

    // long receiver stall so the block backs up into its input
    initial
    begin
        @(hold_go);
        rsp_hold = 1'b1;
        repeat (300) @(posedge clk);
        rsp_hold = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int          occ;
        logic [31:0] k;
        cur_cfg = {5'd0, 32'h0, 32'h1, 5'd0, 8'h1F, 32'h0, 1'b0};
        board = '0;
        buf_sel = 1'b0;
        sync_cnt = SYNC_PARTIES;
        stop_latch = 1'b0;
        dq_head = 0;
        dq_tail = 0;
        delta_busy = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle = 20;
        recv_idle = 88;
        set_regs({5'd8, 32'hFF00_0000, 32'hA500_0000, 5'd3, 8'hFF, 32'h0000_000F, 1'b0});
        queue_req(REQ_PACKET, 32'h0000_0000, 32'h0000_0000);
        queue_req(REQ_PACKET, 32'h1234_5001, 32'hFFFF_FFFF);
        queue_req(REQ_PACKET, 32'h0000_00C8, 32'h8000_0001);   // index past the bitmap
        queue_req(REQ_PACKET, 32'h00FF_00FF, 32'h0000_FFFF);
        queue_req(REQ_PACKET, 32'h0000_0002, 32'h1234_5678);
        queue_req(REQ_PACKET, 32'h0000_0003, 32'hCAFE_F00D);   // board full, buffer flips
        queue_req(REQ_PACKET, 32'hA500_0008, 32'h0000_0000);   // stop with decision set
        queue_req(REQ_DONE, 32'h0000_0000, 32'h0000_0000);     // semaphore at zero
        queue_req(REQ_PACKET, 32'h0000_0100, 32'h1111_1111);
        queue_req(REQ_PACKET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(REQ_DEQ, 32'h0000_0000, 32'h0000_0000);
        queue_req(REQ_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(REQ_DEQ, 32'h0000_0000, 32'h0000_0000);      // empty, work goes idle
        queue_req(REQ_DEQ, 32'h0000_0000, 32'h0000_0000);
        queue_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(REQ_PACKET, 32'h0000_0300, 32'h2222_2222);
        queue_req(REQ_PACKET, 32'hA5FF_FFF7, 32'hFFFF_FFFF);   // stop with decision clear
        queue_req(REQ_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(REQ_DONE, 32'h0000_0000, 32'h0000_0000);
        queue_req(REQ_PACKET, 32'h0000_0000, 32'h0000_0005);
        queue_req(REQ_DEQ, 32'h0000_0000, 32'h0000_0000);
        queue_random(60);
        drain();

        set_regs({5'd31, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 5'd31, 8'h1F, 32'hFFFF_FFFF, 1'b0});
        for (int i = 0; i < 32; i++)
        begin
            k = packet_key(1'b0);
            k[7:0] = 8'(i);
            queue_req(REQ_PACKET, k, $urandom);
        end
        queue_req(REQ_PACKET, 32'hDEAD_BEEF, $urandom);
        // fill the delta queue to the brim, then overflow it
        occ = (dq_tail - dq_head + FIFO_DEPTH) % FIFO_DEPTH;
        for (int i = 0; i < FIFO_DEPTH - 1 - occ + 3; i++)
            queue_req(REQ_PACKET, packet_key(1'b1), $urandom);
        queue_random(60);
        drain();

        send_idle = 88;
        recv_idle = 20;
        set_regs({5'd7, 32'h0, 32'h0, 5'd0, 8'h00, 32'h0, 1'b1});
        queue_random(60);
        drain();

        set_regs({5'd12, 32'h00F0_0000, 32'h0050_0000, 5'd19, 8'h07, board + 32'd5, 1'b1});
        queue_random(100);
        drain();

        send_idle = 0;
        recv_idle = 0;
        set_regs({5'd0, 32'h8000_0001, 32'h8000_0001, 5'd16, 8'h3F,
                  board | 32'h0000_5555, 1'b0});
        queue_random(150);
        @(posedge clk);
        -> hold_go;
        drain();

        repeat (10) @(posedge clk);
        if (err_count == 0 && predicted_rsps.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
src/trpu_pkg.sv
src/trpu_regs.sv
src/trpu_front.sv
src/trpu_fifo.sv
src/trpu_back.sv
src/training_packet_receive_unit.sv
test/training_packet_receive_unit_test.sv
